// ===== rtl/core/gbs_pkg.sv =====
// Shared types and constants of the bitmap sweep and free-run coalescing block.
package gbs_pkg;

   // Cell positions and run ends are carried at this width across the whole
   // parameter range (cells below 2^20, arena size up to 2^20).
   localparam int RUN_W       = 21;
   // Runs closed inside one bitmap byte, and runs per byte with the trailing one.
   localparam int MAX_CLOSES  = 4;
   localparam int MAX_RUNS    = 5;
   localparam int RUN_IDX_W   = 3;
   // Queue between classification and emission.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_WRITEBACK = 2'd0,
      KIND_FREE      = 2'd1,
      KIND_SUMMARY   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_WRITEBACK,
      PHASE_RUN,
      PHASE_SUMMARY
   } phase_type;

   typedef struct packed {
      logic [7:0] block_byte;
      logic [7:0] mark_byte;
      logic       last_byte;
      logic       is_bump_arena;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  new_block_byte;
      logic [7:0]  new_mark_byte;
      logic [12:0] byte_index;
      logic [15:0] free_start;
      logic [16:0] free_length;
      logic [16:0] largest_free;
      logic        arena_empty;
      logic        last;
   } rsp_type;

   // One classified bitmap byte: write-back data, the runs it emits, summary.
   typedef struct packed {
      logic [7:0]                        new_block_byte;
      logic [7:0]                        new_mark_byte;
      logic [12:0]                       byte_index;
      logic [RUN_IDX_W-1:0]              run_count;
      logic [MAX_RUNS-1:0][RUN_W-1:0]    run_start;
      logic [MAX_RUNS-1:0][RUN_W-1:0]    run_end;
      logic                              summary;
      logic                              arena_empty;
   } work_type;

endpackage

// ===== rtl/core/gbs_front.sv =====
// Front end: sweeps one bitmap byte pair, tracks run state, builds a work entry.
module gbs_front #(
   parameter int CELL_COUNT   = 65536,
   parameter int FIRST_CELL   = 1024,
   parameter int BITMAP_BYTES = 8192
) (
   input  logic              clock,
   input  logic              reset,
   input  gbs_pkg::req_type  req_data,
   input  logic              accept,
   output gbs_pkg::work_type work
);

   localparam int FIRST_BYTE = FIRST_CELL / 8;
   localparam int CNT_SPAN   = (BITMAP_BYTES > FIRST_BYTE) ? BITMAP_BYTES : FIRST_BYTE + 1;
   localparam int CNT_W      = $clog2(CNT_SPAN);
   localparam int IDX_W      = (CNT_W > 13) ? CNT_W : 13;

   logic [CNT_W-1:0]          counter_ff, counter_in;
   logic                      run_open_ff, run_open_in;
   logic [gbs_pkg::RUN_W-1:0] run_start_ff, run_start_in;
   logic                      saw_live_ff, saw_live_in;

   // Classify the cells of the byte in order and update the run state
   always_comb begin
      logic [7:0]                    nb;
      logic [7:0]                    nm;
      logic                          open;
      logic                          live;
      logic [gbs_pkg::RUN_W-1:0]     start;
      logic [gbs_pkg::RUN_W-1:0]     cell_pos;
      logic [gbs_pkg::RUN_IDX_W-1:0] n;
      logic [CNT_W:0]                cnt_plus;
      logic [IDX_W-1:0]              idx_wide;

      open     = run_open_ff;
      live     = saw_live_ff;
      start    = run_start_ff;
      cell_pos = '0;
      n        = '0;
      work     = '0;
      idx_wide = IDX_W'(counter_ff);

      if (req_data.is_bump_arena) begin
         nb = req_data.block_byte;
         nm = req_data.mark_byte & ~req_data.block_byte;
      end else begin
         nb = req_data.block_byte & req_data.mark_byte;
         nm = req_data.block_byte ^ req_data.mark_byte;
         for (int j = 0; j < 8; j++) begin
            cell_pos = gbs_pkg::RUN_W'({counter_ff, 3'(j)});
            if (nm[j]) begin
               if (open) begin
                  // merge into the open run
                  nm[j] = 1'b0;
               end else begin
                  open  = 1'b1;
                  start = cell_pos;
               end
            end else if (nb[j]) begin
               live = 1'b1;
               if (open) begin
                  if (n < gbs_pkg::RUN_IDX_W'(gbs_pkg::MAX_CLOSES)) begin
                     work.run_start[n] = start;
                     work.run_end[n]   = cell_pos;
                     n = n + 1'b1;
                  end
                  open = 1'b0;
               end
            end
         end
      end

      // Emit the trailing run only when live cells remain
      if (req_data.last_byte && !req_data.is_bump_arena && open && live) begin
         work.run_start[n] = start;
         work.run_end[n]   = gbs_pkg::RUN_W'(CELL_COUNT);
         n = n + 1'b1;
      end

      work.new_block_byte = nb;
      work.new_mark_byte  = nm;
      work.byte_index     = idx_wide[12:0];
      work.run_count      = n;
      work.summary        = req_data.last_byte;
      work.arena_empty    = req_data.last_byte && !req_data.is_bump_arena && !live;

      // Advance the counter on an accepted byte, wrapping past the end of the bitmap; a last byte restarts the sweep
      cnt_plus = {1'b0, counter_ff} + (CNT_W + 1)'(1);
      counter_in   = counter_ff;
      run_open_in  = run_open_ff;
      run_start_in = run_start_ff;
      saw_live_in  = saw_live_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            counter_in   = CNT_W'(FIRST_BYTE);
            run_open_in  = 1'b0;
            run_start_in = '0;
            saw_live_in  = 1'b0;
         end else begin
            if (cnt_plus >= (CNT_W + 1)'(BITMAP_BYTES)) begin
               counter_in = CNT_W'(FIRST_BYTE);
            end else begin
               counter_in = cnt_plus[CNT_W-1:0];
            end
            run_open_in  = open;
            run_start_in = start;
            saw_live_in  = live;
         end
      end
   end

   // Hold the sweep state
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= CNT_W'(FIRST_BYTE);
         run_open_ff  <= 1'b0;
         run_start_ff <= '0;
         saw_live_ff  <= 1'b0;
      end else begin
         counter_ff   <= counter_in;
         run_open_ff  <= run_open_in;
         run_start_ff <= run_start_in;
         saw_live_ff  <= saw_live_in;
      end
   end

endmodule

// ===== rtl/core/gbs_queue.sv =====
// Short queue of work entries between the front and back ends.
module gbs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gbs_pkg::work_type push_data,
   output logic              full,
   output logic              valid,
   input  logic              pop,
   output gbs_pkg::work_type pop_data
);

   gbs_pkg::work_type                 entry_ff [gbs_pkg::QUEUE_DEPTH];
   logic [gbs_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [gbs_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [gbs_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              do_push, do_pop;

   assign full     = (count_ff == gbs_pkg::QCNT_W'(gbs_pkg::QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == gbs_pkg::QPTR_W'(gbs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == gbs_pkg::QPTR_W'(gbs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/gbs_back.sv =====
// Back end: walks an entry one result per cycle while taken, into output reg.
module gbs_back (
   input  logic              clock,
   input  logic              reset,
   input  gbs_pkg::work_type work,
   input  logic              work_valid,
   output logic              work_pop,
   output gbs_pkg::rsp_type  rsp_data,
   output logic              rsp_empty,
   input  logic              rsp_pop
);

   gbs_pkg::phase_type            phase_ff, phase_in;
   logic [gbs_pkg::RUN_IDX_W-1:0] run_idx_ff, run_idx_in;
   logic [16:0]                   largest_ff, largest_in;
   gbs_pkg::rsp_type              out_ff, out_in;
   logic                          out_valid_ff, out_valid_in;

   // Sequence write-back, runs and summary; update the largest run
   always_comb begin
      gbs_pkg::rsp_type              res;
      gbs_pkg::phase_type            nxt_phase;
      logic [gbs_pkg::RUN_IDX_W-1:0] nxt_idx;
      logic                          done;
      logic                          fire;
      logic                          last_run;
      logic [gbs_pkg::RUN_W-1:0]     diff;
      logic [16:0]                   len;
      logic [16:0]                   big;

      fire     = work_valid && (!out_valid_ff || rsp_pop);
      diff     = work.run_end[run_idx_ff] - work.run_start[run_idx_ff];
      len      = diff[16:0];
      big      = (len > largest_ff) ? len : largest_ff;
      last_run = ((run_idx_ff + 1'b1) == work.run_count);
      res       = '0;
      nxt_phase = phase_ff;
      nxt_idx   = run_idx_ff;
      done      = 1'b0;

      case (phase_ff)
         gbs_pkg::PHASE_WRITEBACK: begin
            res.kind           = gbs_pkg::KIND_WRITEBACK;
            res.new_block_byte = work.new_block_byte;
            res.new_mark_byte  = work.new_mark_byte;
            res.byte_index     = work.byte_index;
            res.largest_free   = largest_ff;
            nxt_idx            = '0;
            if (work.run_count != '0) begin
               nxt_phase = gbs_pkg::PHASE_RUN;
            end else if (work.summary) begin
               nxt_phase = gbs_pkg::PHASE_SUMMARY;
            end else begin
               done = 1'b1;
            end
         end
         gbs_pkg::PHASE_RUN: begin
            res.kind         = gbs_pkg::KIND_FREE;
            res.free_start   = work.run_start[run_idx_ff][15:0];
            res.free_length  = len;
            res.largest_free = big;
            if (!last_run) begin
               nxt_idx = run_idx_ff + 1'b1;
            end else if (work.summary) begin
               nxt_phase = gbs_pkg::PHASE_SUMMARY;
            end else begin
               done = 1'b1;
            end
         end
         gbs_pkg::PHASE_SUMMARY: begin
            res.kind         = gbs_pkg::KIND_SUMMARY;
            res.arena_empty  = work.arena_empty;
            res.largest_free = largest_ff;
            done             = 1'b1;
         end
         default: begin
            nxt_phase = gbs_pkg::PHASE_WRITEBACK;
         end
      endcase
      res.last = done;

      phase_in     = phase_ff;
      run_idx_in   = run_idx_ff;
      largest_in   = largest_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      work_pop     = 1'b0;
      if (fire) begin
         out_in       = res;
         out_valid_in = 1'b1;
         run_idx_in   = nxt_idx;
         phase_in     = done ? gbs_pkg::PHASE_WRITEBACK : nxt_phase;
         work_pop     = done;
         if (phase_ff == gbs_pkg::PHASE_RUN) begin
            largest_in = big;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= gbs_pkg::PHASE_WRITEBACK;
         run_idx_ff   <= '0;
         largest_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         run_idx_ff   <= run_idx_in;
         largest_ff   <= largest_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the result beat until it is taken
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_data  = out_ff;
   assign rsp_empty = !out_valid_ff;

endmodule

// ===== rtl/core/gc_bitmap_sweep_coalesce.sv =====
// Top level of the bitmap sweeper with free-run coalescing.
//
// Each accepted beat is one block/mark bitmap byte pair, taken in order from
// byte FIRST_CELL/8. The front end classifies the byte in the cycle it is
// accepted and queues a work entry (two deep); the back end turns each entry
// into result beats, one per cycle while results are taken: a write-back,
// each free run closed in the byte (up to four), then on the last byte the
// trailing run if live cells remain and the summary. A byte yields 1 to 7
// result beats; the sustained rate is one byte per cycle while bytes produce
// only their write-back and results are taken; the back-end sequencer sets
// the rate otherwise. The largest run is kept across sweeps until reset.
module gc_bitmap_sweep_coalesce #(
   parameter int CELL_COUNT   = 65536,
   parameter int FIRST_CELL   = 1024,
   parameter int BITMAP_BYTES = 8192
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  gbs_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output gbs_pkg::rsp_type rsp_data
);

   gbs_pkg::work_type front_work;
   gbs_pkg::work_type head_work;
   logic              accept;
   logic              head_valid;
   logic              head_pop;

   assign accept = req_push && !req_full;

   // Classify incoming bytes
   gbs_front #(
      .CELL_COUNT  (CELL_COUNT),
      .FIRST_CELL  (FIRST_CELL),
      .BITMAP_BYTES(BITMAP_BYTES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .accept  (accept),
      .work    (front_work)
   );

   // Decouple classification from emission
   gbs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(front_work),
      .full     (req_full),
      .valid    (head_valid),
      .pop      (head_pop),
      .pop_data (head_work)
   );

   // Emit result beats
   gbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .work      (head_work),
      .work_valid(head_valid),
      .work_pop  (head_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   // A summary always closes the results of its byte
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind == gbs_pkg::KIND_SUMMARY) |-> rsp_data.last)
      else $error("summary beat without last");

   // Only write-back beats carry bitmap data
   a_bitmap_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind != gbs_pkg::KIND_WRITEBACK) |->
      (rsp_data.new_block_byte == 8'd0 && rsp_data.new_mark_byte == 8'd0))
      else $error("bitmap data on a non write-back beat");

   // The largest run never shrinks from one beat to the next
   a_largest_grows: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop) |=>
      (rsp_empty || rsp_data.largest_free >= $past(rsp_data.largest_free)))
      else $error("largest free run decreased");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the bitmap sweeper with free-run coalescing.
module testbench;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 9;
   localparam int CELL_COUNT     = 65536;
   localparam int FIRST_CELL     = 1024;
   localparam int BITMAP_BYTES   = 8192;
   localparam int RANDOM_BYTES   = 214;
   localparam int TAIL_BYTES     = 16;
   localparam int DRAIN_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int TIMEOUT_CYCLES = 3000000;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [12:0] FIRST_BYTE = 13'(FIRST_CELL / 8);
   localparam logic [12:0] FINAL_BYTE = 13'(BITMAP_BYTES - 1);

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_push  = 1'b0;
   logic             req_full;
   gbs_pkg::req_type req_data  = '0;
   logic             rsp_empty;
   logic             rsp_pop   = 1'b0;
   gbs_pkg::rsp_type rsp_data;

   // sweep state of the predictor
   logic [12:0] sweep_byte_pos;
   logic        run_active;
   logic [15:0] run_first_cell;
   logic        live_seen;
   logic [16:0] longest_run;

   gbs_pkg::rsp_type expected_beats[$];
   int               fail_count = 0;
   bit               idle_on    = 1'b1;
   int               pop_hold   = 0;

   gc_bitmap_sweep_coalesce #(
      .CELL_COUNT  (CELL_COUNT),
      .FIRST_CELL  (FIRST_CELL),
      .BITMAP_BYTES(BITMAP_BYTES)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

   // 12 ns clock
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // hard stop if the run hangs
   initial begin
      #(2 * CLOCK_HALF * TIMEOUT_CYCLES);
      $display("gc_bitmap_sweep_coalesce verification failed");
      $finish;
   end

   task automatic note_failure(input string what);
      if (fail_count < REPORT_LIMIT) begin
         $display("%0t ns: %s", $time, what);
      end
      fail_count++;
   endtask

   // Sweep one bitmap byte and queue the beats it should produce.
   task automatic sweep_byte(input gbs_pkg::req_type item);
      logic [7:0]       nb;
      logic [7:0]       nm;
      logic [15:0]      cell_pos;
      logic [15:0]      close_first[$];
      logic [16:0]      close_len[$];
      logic [16:0]      len;
      logic             empty;
      gbs_pkg::rsp_type beats[$];
      gbs_pkg::rsp_type r;
      if (item.is_bump_arena) begin
         nb = item.block_byte;
         nm = item.mark_byte & ~item.block_byte;
      end else begin
         nb = item.block_byte & item.mark_byte;
         nm = item.block_byte ^ item.mark_byte;
         for (int j = 0; j < 8; j++) begin
            cell_pos = {sweep_byte_pos, 3'(j)};
            if (nm[j]) begin
               // merge into an open run, else open a new one
               if (run_active) begin
                  nm[j] = 1'b0;
               end else begin
                  run_active     = 1'b1;
                  run_first_cell = cell_pos;
               end
            end else if (nb[j]) begin
               live_seen = 1'b1;
               if (run_active) begin
                  close_first.push_back(run_first_cell);
                  close_len.push_back({1'b0, cell_pos} - {1'b0, run_first_cell});
                  run_active = 1'b0;
               end
            end
         end
      end

      // write-back carries the largest run before this byte's closes
      r                = '0;
      r.kind           = gbs_pkg::KIND_WRITEBACK;
      r.new_block_byte = nb;
      r.new_mark_byte  = nm;
      r.byte_index     = sweep_byte_pos;
      r.largest_free   = longest_run;
      beats.push_back(r);

      foreach (close_first[i]) begin
         if (close_len[i] > longest_run) longest_run = close_len[i];
         r              = '0;
         r.kind         = gbs_pkg::KIND_FREE;
         r.free_start   = close_first[i];
         r.free_length  = close_len[i];
         r.largest_free = longest_run;
         beats.push_back(r);
      end

      if (item.last_byte) begin
         empty = item.is_bump_arena ? 1'b0 : !live_seen;
         // trailing run only when live cells remain
         if (!item.is_bump_arena && run_active && !empty) begin
            len = 17'(CELL_COUNT) - {1'b0, run_first_cell};
            if (len > longest_run) longest_run = len;
            r              = '0;
            r.kind         = gbs_pkg::KIND_FREE;
            r.free_start   = run_first_cell;
            r.free_length  = len;
            r.largest_free = longest_run;
            beats.push_back(r);
         end
         r              = '0;
         r.kind         = gbs_pkg::KIND_SUMMARY;
         r.largest_free = longest_run;
         r.arena_empty  = empty;
         beats.push_back(r);
         sweep_byte_pos = FIRST_BYTE;
         run_active     = 1'b0;
         run_first_cell = '0;
         live_seen      = 1'b0;
      end else if (sweep_byte_pos == FINAL_BYTE) begin
         sweep_byte_pos = FIRST_BYTE;
      end else begin
         sweep_byte_pos = sweep_byte_pos + 13'd1;
      end

      beats[beats.size() - 1].last = 1'b1;
      foreach (beats[i]) expected_beats.push_back(beats[i]);
   endtask

   task automatic compare_field(input string name, input logic [16:0] want,
                                input logic [16:0] got);
      if (want !== got) begin
         note_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
      end
   endtask

   // Check one result beat against the oldest expectation.
   task automatic check_beat(input gbs_pkg::rsp_type got);
      gbs_pkg::rsp_type want;
      if (expected_beats.size() == 0) begin
         note_failure($sformatf("result beat with nothing expected: %h", got));
         return;
      end
      want = expected_beats.pop_front();
      compare_field("kind", 17'(want.kind), 17'(got.kind));
      compare_field("new_block_byte", 17'(want.new_block_byte), 17'(got.new_block_byte));
      compare_field("new_mark_byte", 17'(want.new_mark_byte), 17'(got.new_mark_byte));
      compare_field("byte_index", 17'(want.byte_index), 17'(got.byte_index));
      compare_field("free_start", 17'(want.free_start), 17'(got.free_start));
      compare_field("free_length", want.free_length, got.free_length);
      compare_field("largest_free", want.largest_free, got.largest_free);
      compare_field("arena_empty", 17'(want.arena_empty), 17'(got.arena_empty));
      compare_field("last", 17'(want.last), 17'(got.last));
   endtask

   // Take result beats, stalling in random bursts while idling is on.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         check_beat(rsp_data);
      end
      if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         pop_hold <= $urandom_range(0, 6);
         rsp_pop  <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Offer one byte pair and hold it until accepted.
   task automatic send_byte(input logic [7:0] blk, input logic [7:0] mrk,
                            input bit is_last, input bit bump);
      gbs_pkg::req_type item;
      item.block_byte    = blk;
      item.mark_byte     = mrk;
      item.last_byte     = is_last;
      item.is_bump_arena = bump;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      sweep_byte(item);
   endtask

   // Every cell code, byte extremes, four closes in a byte, the widest byte.
   task automatic test_cell_codes();
      send_byte(8'hFF, 8'hFF, 1'b0, 1'b0);
      send_byte(8'hFF, 8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 8'hFF, 1'b0, 1'b0);
      send_byte(8'hAA, 8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 8'h01, 1'b0, 1'b0);
      // four closes plus the trailing run plus the summary
      send_byte(8'h55, 8'hFF, 1'b1, 1'b0);
   endtask

   // Arena with no live cell: open run at the end is not emitted.
   task automatic test_empty_arena();
      send_byte(8'h00, 8'hFF, 1'b0, 1'b0);
      send_byte(8'hFF, 8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 8'h00, 1'b0, 1'b0);
      send_byte(8'h0F, 8'hF0, 1'b1, 1'b0);
      send_byte(8'h00, 8'h00, 1'b1, 1'b0);
   endtask

   // Bump bytes leave run state alone; a bump last byte ends without a run.
   task automatic test_bump_bytes();
      send_byte(8'h00, 8'hFF, 1'b0, 1'b0);
      send_byte(8'hA5, 8'h5A, 1'b0, 1'b1);
      send_byte(8'hFF, 8'hFF, 1'b0, 1'b1);
      send_byte(8'h00, 8'h0F, 1'b1, 1'b1);
      send_byte(8'hFF, 8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 8'hFF, 1'b0, 1'b1);
      send_byte(8'h80, 8'hFF, 1'b1, 1'b0);
   endtask

   // Short random sweeps with a mix of sparse live data and long free runs.
   task automatic test_random_sweeps();
      int         sent;
      int         sweep_len;
      bit         bump_sweep;
      bit         bump;
      logic [7:0] blk;
      logic [7:0] mrk;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         sweep_len  = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 14);
         bump_sweep = ($urandom_range(0, 6) == 0);
         idle_on    = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < sweep_len; i++) begin
            case ($urandom_range(0, 3))
               0: begin
                  blk = 8'($urandom);
                  mrk = 8'($urandom);
               end
               1: begin
                  blk = 8'($urandom) & 8'($urandom) & 8'($urandom);
                  mrk = 8'($urandom) | blk;
               end
               2: begin
                  blk = 8'h00;
                  mrk = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'($urandom);
               end
               default: begin
                  blk = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                  mrk = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
               end
            endcase
            // occasional stray byte of the other kind, in either kind of sweep
            bump = bump_sweep ^ ($urandom_range(0, 19) == 0);
            send_byte(blk, mrk, i == sweep_len - 1, bump);
            sent++;
         end
      end
      idle_on = 1'b1;
   endtask

   // Close the run with one sweep of random bytes sent back to back, no idling.
   task automatic test_back_to_back();
      idle_on = 1'b0;
      for (int i = 0; i < TAIL_BYTES; i++) begin
         send_byte(8'($urandom), 8'($urandom), i == TAIL_BYTES - 1, 1'b0);
      end
   endtask

   initial begin
      int waited;
      sweep_byte_pos = FIRST_BYTE;
      run_active     = 1'b0;
      run_first_cell = '0;
      live_seen      = 1'b0;
      longest_run    = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cell_codes();
      test_empty_arena();
      test_bump_bytes();
      test_random_sweeps();
      test_back_to_back();

      // drain the result side
      req_push <= 1'b0;
      waited = 0;
      while (expected_beats.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_beats.size() != 0) begin
         note_failure($sformatf("%0d result beats never arrived", expected_beats.size()));
      end

      if (fail_count == 0) begin
         $display("gc_bitmap_sweep_coalesce verification clean");
      end else begin
         $display("gc_bitmap_sweep_coalesce verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/gbs_pkg.sv
rtl/core/gbs_front.sv
rtl/core/gbs_queue.sv
rtl/core/gbs_back.sv
rtl/core/gc_bitmap_sweep_coalesce.sv
tb/sv/testbench.sv
